@@ sv/pomt_pkg.sv @@
// ----------------------------------------------------------------------------
// pomt_pkg: per-owner permission bitmap table, shared definitions
// Sizes, request/response codes and the structs passed between the top
// level, the slot row and the slot cells.
// ----------------------------------------------------------------------------
package pomt_pkg;

	localparam int SLOTS      = 64;
	localparam int LAST_PERM  = 40;
	localparam int OWNER_BITS = 16;
	localparam int PERM_W     = LAST_PERM + 1;

	typedef enum logic [1:0] {
		ACT_GET = 2'd0,
		ACT_SET = 2'd1,
		ACT_CLR = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	// Update command broadcast to every slot cell in the action cycle
	typedef struct packed {
		logic                  go_set;
		logic                  go_clr;
		logic                  en;
		logic [PERM_W-1:0]     mask;
		logic [OWNER_BITS-1:0] owner;
	} pomt_cmd_t;

	// Priority chain handed from one cell to the next
	typedef struct packed {
		logic match_seen;
		logic free_seen;
		logic rd_bit;
	} pomt_chain_t;

endpackage

@@ sv/pomt_if.sv @@
// ----------------------------------------------------------------------------
// pomt_if: request and response channels
// Valid/ready channels carrying the table request and its response.
// ----------------------------------------------------------------------------
interface pomt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [15:0] owner_id;
	logic [6:0] perm_index;
	logic       enable;

	modport source (output valid, action, owner_id, perm_index, enable, input ready);
	modport sink   (input valid, action, owner_id, perm_index, enable, output ready);
endinterface

interface pomt_rsp_if;
	logic       valid;
	logic       ready;
	logic       perm_bit;
	logic [1:0] status;

	modport source (output valid, perm_bit, status, input ready);
	modport sink   (input valid, perm_bit, status, output ready);
endinterface

@@ sv/per_owner_permission_bitmap_table_unit.sv @@
// ----------------------------------------------------------------------------
// per_owner_permission_bitmap_table_unit: owner-keyed permission bitmaps
// Get, set/clear and clear-all on a table of slots keyed by owner id.
//
//   channel | dir | payload                                 | handshake
//   req     | in  | action, owner_id, perm_index, enable    | valid/ready
//   rsp     | out | perm_bit, status                        | valid/ready
//
// Per request: the accept edge registers every slot's owner compare,
// then the action state resolves the first-match / first-free chain
// across the slot row, updates the slot and loads the response register.
// A new request is taken while the previous response still waits.
// A stalled response holds the action cycle; the table is updated once.
// Reset clears every slot (owner 0, bitmap 0) at once.
// ----------------------------------------------------------------------------
module per_owner_permission_bitmap_table_unit import pomt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	pomt_req_if.sink        req,
	pomt_rsp_if.source      rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_ACT  = 2'b10
	} state_t;

	state_t                state_q;
	action_t               act_s1;
	logic                  idx_ok_s1;
	logic [PERM_W-1:0]     mask_s1;
	logic [OWNER_BITS-1:0] owner_s1;
	logic                  en_s1;

	logic                  rsp_valid_q;
	logic                  perm_bit_q;
	status_t               status_q;

	logic                  accept;
	logic                  act_fire;
	logic [OWNER_BITS-1:0] in_owner;
	pomt_cmd_t             cmd;
	pomt_chain_t           summary;
	logic                  res_bit;
	status_t               res_status;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;
	assign act_fire  = (state_q == S_ACT) & (~rsp_valid_q | rsp.ready);
	assign in_owner  = OWNER_BITS'(req.owner_id);

	assign cmd.go_set = act_fire & (act_s1 == ACT_SET) & idx_ok_s1;
	assign cmd.go_clr = act_fire & (act_s1 == ACT_CLR);
	assign cmd.en     = en_s1;
	assign cmd.mask   = mask_s1;
	assign cmd.owner  = owner_s1;

	pomt_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmp_en    (accept),
		.cmp_owner (in_owner),
		.cmd       (cmd),
		.summary   (summary)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_ACT;
				S_ACT:  if (act_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= action_t'(req.action);
			idx_ok_s1 <= (req.perm_index <= 7'(LAST_PERM));
			mask_s1   <= PERM_W'(1) << req.perm_index;
			owner_s1  <= in_owner;
			en_s1     <= req.enable;
		end
	end

	always_comb begin
		res_bit    = 1'b0;
		res_status = ST_OK;
		case (act_s1)
			ACT_GET: res_bit = idx_ok_s1 & summary.rd_bit;
			ACT_SET: begin
				if (!idx_ok_s1)
					res_status = ST_BAD_INDEX;
				else if (!summary.match_seen && !summary.free_seen)
					res_status = ST_FULL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (act_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act_fire) begin
			perm_bit_q <= res_bit;
			status_q   <= res_status;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.perm_bit = perm_bit_q;
	assign rsp.status   = status_q;

endmodule

@@ sv/pomt_cell.sv @@
// ----------------------------------------------------------------------------
// pomt_cell: one table slot
// Holds an owner id and its bitmap, registers its owner compare and takes
// its place in the first-match / first-free priority chain.
// ----------------------------------------------------------------------------
module pomt_cell import pomt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmp_en,
	input  logic [OWNER_BITS-1:0] cmp_owner,
	input  pomt_cmd_t             cmd,
	input  logic                  none_match,
	input  pomt_chain_t           chain_in,
	output pomt_chain_t           chain_out
);

	logic [OWNER_BITS-1:0] owner_q;
	logic [PERM_W-1:0]     bits_q;
	logic                  match_q;
	logic                  free_q;
	logic                  hit;
	logic                  claim;

	assign hit   = match_q & ~chain_in.match_seen;
	assign claim = free_q & ~chain_in.free_seen & none_match;

	assign chain_out.match_seen = chain_in.match_seen | match_q;
	assign chain_out.free_seen  = chain_in.free_seen | free_q;
	assign chain_out.rd_bit     = chain_in.rd_bit | (hit & (|(bits_q & cmd.mask)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmp_en) begin
			match_q <= (owner_q == cmp_owner);
			free_q  <= (owner_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			bits_q  <= '0;
		end else if (cmd.go_set && (hit || claim)) begin
			if (claim) begin
				owner_q <= cmd.owner;
			end
			bits_q <= cmd.en ? (bits_q | cmd.mask) : (bits_q & ~cmd.mask);
		end else if (cmd.go_clr && hit) begin
			bits_q <= '0;
		end
	end

endmodule

@@ sv/pomt_row.sv @@
// ----------------------------------------------------------------------------
// pomt_row: row of slot cells
// Chains the cells from slot 0 upward and reports the row summary.
// ----------------------------------------------------------------------------
module pomt_row import pomt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmp_en,
	input  logic [OWNER_BITS-1:0] cmp_owner,
	input  pomt_cmd_t             cmd,
	output pomt_chain_t           summary
);

	pomt_chain_t chain [SLOTS+1];
	logic        none_match;

	assign chain[0]   = '0;
	assign summary    = chain[SLOTS];
	// no match anywhere: a set falls back to the first free slot
	assign none_match = ~chain[SLOTS].match_seen;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		pomt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (cmp_en),
			.cmp_owner  (cmp_owner),
			.cmd        (cmd),
			.none_match (none_match),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1])
		);
	end

endmodule
